// ===== sv/csi_pkg.sv =====
// Types, field widths and rank weights for the cube state pattern index block.
// No dependencies; every other file of the block imports it.
package csi_pkg;

	localparam int CORNERS      = 8;
	localparam int TWISTS       = 7;
	localparam int EDGES        = 12;
	localparam int HALF         = 6;
	localparam int TWIST_SCALE  = 2187;

	localparam int CSLOTS_W = 24;
	localparam int CTWIST_W = 14;
	localparam int ESLOTS_W = 48;
	localparam int EFLIPS_W = 12;
	localparam int CIDX_W   = 27;
	localparam int EIDX_W   = 26;

	localparam int CRANK_W  = 16;
	localparam int TSUM_W   = 12;
	localparam int ERANK_W  = EIDX_W - HALF;
	localparam int ETERM_W  = 5;

	typedef logic [2:0]          cnt_t;
	typedef logic [ETERM_W-1:0]  eterm_t;
	typedef logic [CRANK_W-1:0]  crank_t;
	typedef logic [TSUM_W-1:0]   tsum_t;
	typedef logic [ERANK_W-1:0]  erank_t;

	typedef logic [CRANK_W-1:0] fact_tab_t [CORNERS];
	typedef logic [ERANK_W-1:0] fall_tab_t [HALF];
	typedef logic [TSUM_W-1:0]  pow3_tab_t [TWISTS];

	localparam fact_tab_t FACT_W = '{16'd1, 16'd1, 16'd2, 16'd6, 16'd24, 16'd120,
		16'd720, 16'd5040};
	localparam fall_tab_t FALL_W = '{20'd55440, 20'd5040, 20'd504, 20'd56, 20'd7, 20'd1};
	localparam pow3_tab_t POW3_W = '{12'd1, 12'd3, 12'd9, 12'd27, 12'd81, 12'd243, 12'd729};

	typedef struct packed {
		cnt_t [CORNERS-1:0]   larger;
		tsum_t                twist;
		eterm_t [EDGES-1:0]   eterm;
		logic [EFLIPS_W-1:0]  flips;
	} s1_t;

	typedef struct packed {
		crank_t               crank;
		tsum_t                twist;
		erank_t               erank0;
		erank_t               erank1;
		logic [EFLIPS_W-1:0]  flips;
	} s2_t;

	typedef struct packed {
		logic [CIDX_W-1:0] corner_index;
		logic [EIDX_W-1:0] first_edge_index;
		logic [EIDX_W-1:0] second_edge_index;
	} s3_t;

	typedef struct packed {
		logic en1;
		logic en2;
		logic en3;
	} stage_en_t;

endpackage

// ===== sv/csi_ifs.sv =====
// Valid/ready channel interfaces for the packed cube state and its indices.
// Depends on csi_pkg for field widths.
interface csi_state_if;
	import csi_pkg::*;
	logic                valid;
	logic                ready;
	logic [CSLOTS_W-1:0] corner_slots;
	logic [CTWIST_W-1:0] corner_twists;
	logic [ESLOTS_W-1:0] edge_slots;
	logic [EFLIPS_W-1:0] edge_flips;
	modport source (output valid, corner_slots, corner_twists, edge_slots, edge_flips,
		input ready);
	modport sink (input valid, corner_slots, corner_twists, edge_slots, edge_flips,
		output ready);
endinterface

interface csi_index_if;
	import csi_pkg::*;
	logic              valid;
	logic              ready;
	logic [CIDX_W-1:0] corner_index;
	logic [EIDX_W-1:0] first_edge_index;
	logic [EIDX_W-1:0] second_edge_index;
	modport source (output valid, corner_index, first_edge_index, second_edge_index,
		input ready);
	modport sink (input valid, corner_index, first_edge_index, second_edge_index,
		output ready);
endinterface

// ===== sv/csi_compare.sv =====
// Stage 1: pairwise piece compares per slot and the base-3 twist sum.
// Depends on csi_pkg.
module csi_compare (
	input  logic                         clk,
	input  logic                         en,
	input  logic [csi_pkg::CSLOTS_W-1:0] corner_slots,
	input  logic [csi_pkg::CTWIST_W-1:0] corner_twists,
	input  logic [csi_pkg::ESLOTS_W-1:0] edge_slots,
	input  logic [csi_pkg::EFLIPS_W-1:0] edge_flips,
	output csi_pkg::s1_t                 q_s1
);
	import csi_pkg::*;

	s1_t d;

	always_comb begin
		logic [2:0] cp [CORNERS];
		logic [3:0] ep [EDGES];
		cnt_t       cnt;
		d = '0;
		for (int i = 0; i < CORNERS; i++) cp[i] = corner_slots[3*i +: 3];
		for (int i = 0; i < EDGES; i++) ep[i] = edge_slots[4*i +: 4];
		for (int i = 0; i < CORNERS; i++) begin
			cnt = '0;
			for (int j = 0; j < i; j++)
				if (cp[i] < cp[j]) cnt = cnt + 3'd1;
			d.larger[i] = cnt;
		end
		for (int i = 0; i < TWISTS; i++)
			d.twist = d.twist + TSUM_W'(corner_twists[2*i +: 2]) * POW3_W[i];
		for (int h = 0; h < 2; h++) begin
			for (int p = 0; p < HALF; p++) begin
				cnt = '0;
				for (int q = 0; q < p; q++)
					if (ep[h*HALF+p] > ep[h*HALF+q]) cnt = cnt + 3'd1;
				d.eterm[h*HALF+p] = {1'b0, ep[h*HALF+p]} - ETERM_W'(cnt);
			end
		end
		d.flips = edge_flips;
	end

	always_ff @(posedge clk) begin
		if (en) q_s1 <= d;
	end
endmodule

// ===== sv/csi_weigh.sv =====
// Stage 2: factorial and falling-factorial weighted rank sums.
// Depends on csi_pkg.
module csi_weigh (
	input  logic         clk,
	input  logic         en,
	input  csi_pkg::s1_t d_s1,
	output csi_pkg::s2_t q_s2
);
	import csi_pkg::*;

	s2_t d;

	always_comb begin
		erank_t r [2];
		d = '0;
		for (int i = 1; i < CORNERS; i++)
			d.crank = d.crank + CRANK_W'(d_s1.larger[i]) * FACT_W[i];
		for (int h = 0; h < 2; h++) begin
			r[h] = '0;
			for (int p = 0; p < HALF; p++)
				r[h] = r[h] + ERANK_W'({{(ERANK_W-ETERM_W){d_s1.eterm[h*HALF+p][ETERM_W-1]}},
					d_s1.eterm[h*HALF+p]}) * FALL_W[p];
		end
		d.erank0 = r[0];
		d.erank1 = r[1];
		d.twist  = d_s1.twist;
		d.flips  = d_s1.flips;
	end

	always_ff @(posedge clk) begin
		if (en) q_s2 <= d;
	end
endmodule

// ===== sv/csi_scale.sv =====
// Stage 3: corner rank times 2187 plus twists, edge ranks packed with flip bits.
// Depends on csi_pkg.
module csi_scale (
	input  logic         clk,
	input  logic         en,
	input  csi_pkg::s2_t d_s2,
	output csi_pkg::s3_t q_s3
);
	import csi_pkg::*;

	s3_t d;

	always_comb begin
		logic [CIDX_W:0]  prod;
		logic [HALF-1:0]  fb [2];
		prod = (CIDX_W+1)'(d_s2.crank) * (CIDX_W+1)'(TWIST_SCALE)
			+ (CIDX_W+1)'(d_s2.twist);
		for (int h = 0; h < 2; h++)
			for (int p = 0; p < HALF; p++)
				fb[h][HALF-1-p] = d_s2.flips[h*HALF+p];
		d.corner_index      = prod[CIDX_W-1:0];
		d.first_edge_index  = {d_s2.erank0, fb[0]};
		d.second_edge_index = {d_s2.erank1, fb[1]};
	end

	always_ff @(posedge clk) begin
		if (en) q_s3 <= d;
	end
endmodule

// ===== sv/cube_state_pattern_index.sv =====
// Cube state pattern index: one packed cube state per transfer in, one set of
// three pattern-database indices out. Three register stages (compare, weighted
// sum, scale/pack) take one state per cycle, and each stage holds while the stage
// after it is full and stalled. Depends on csi_pkg, csi_ifs, csi_compare,
// csi_weigh and csi_scale.
module cube_state_pattern_index (
	input  logic        clk,
	input  logic        arst_n,
	csi_state_if.sink   state,
	csi_index_if.source index
);
	import csi_pkg::*;

	logic      v_s1, v_s2, v_s3;
	stage_en_t en;
	s1_t       p_s1;
	s2_t       p_s2;
	s3_t       p_s3;

	assign en.en3 = !v_s3 || index.ready;
	assign en.en2 = !v_s2 || en.en3;
	assign en.en1 = !v_s1 || en.en2;
	assign state.ready = en.en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en.en1) v_s1 <= state.valid;
			if (en.en2) v_s2 <= v_s1;
			if (en.en3) v_s3 <= v_s2;
		end
	end

	csi_compare u_compare (
		.clk           (clk),
		.en            (en.en1),
		.corner_slots  (state.corner_slots),
		.corner_twists (state.corner_twists),
		.edge_slots    (state.edge_slots),
		.edge_flips    (state.edge_flips),
		.q_s1          (p_s1)
	);

	csi_weigh u_weigh (
		.clk  (clk),
		.en   (en.en2),
		.d_s1 (p_s1),
		.q_s2 (p_s2)
	);

	csi_scale u_scale (
		.clk  (clk),
		.en   (en.en3),
		.d_s2 (p_s2),
		.q_s3 (p_s3)
	);

	assign index.valid             = v_s3;
	assign index.corner_index      = p_s3.corner_index;
	assign index.first_edge_index  = p_s3.first_edge_index;
	assign index.second_edge_index = p_s3.second_edge_index;

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && v_s2 && v_s3 && !index.ready) |-> !state.ready)
		else $error("input taken while pipeline full and stalled");

	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s3 |-> state.ready)
		else $error("input held while output stage empty");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(state.valid && state.ready) |=> v_s1)
		else $error("transfer lost at stage 1");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && v_s3 && !index.ready) |=> (v_s2 && v_s3))
		else $error("stalled stage dropped an item");
endmodule

// ===== bench/csi_index_checker.sv =====
// Checker for cube_state_pattern_index: watches the state and index channels,
// predicts the three pattern-database indices of every accepted state and
// compares them in order. Depends on csi_pkg and csi_ifs.
module csi_index_checker (
	input  logic clk,
	input  logic arst_n,
	csi_state_if st,
	csi_index_if ix,
	output int   fail_count,
	output int   pending
);
	import csi_pkg::*;

	localparam int unsigned CORNER_WEIGHT [CORNERS] = '{1, 1, 2, 6, 24, 120, 720, 5040};
	localparam int unsigned EDGE_WEIGHT [HALF] = '{55440, 5040, 504, 56, 7, 1};
	localparam int MAX_REPORTS = 10;

	s3_t expected_index [$];
	s3_t want;

	function automatic s3_t rank_cube_state(logic [CSLOTS_W-1:0] cs, logic [CTWIST_W-1:0] ct,
			logic [ESLOTS_W-1:0] es, logic [EFLIPS_W-1:0] ef);
		logic [2:0]        cp [CORNERS];
		logic [3:0]        ep [HALF];
		logic [HALF-1:0]   fl;
		logic [EIDX_W-1:0] eidx [2];
		int unsigned       crank, tsum, pow3, larger, csum, erank, term;
		s3_t               r;
		crank = 0;
		tsum = 0;
		pow3 = 1;
		for (int i = 0; i < CORNERS; i++)
			cp[i] = cs[3*i +: 3];
		for (int i = 1; i < CORNERS; i++) begin
			larger = 0;
			for (int j = 0; j < i; j++)
				if (cp[i] < cp[j])
					larger++;
			crank += larger * CORNER_WEIGHT[i];
		end
		for (int i = 0; i < TWISTS; i++) begin
			tsum += ct[2*i +: 2] * pow3;
			pow3 *= 3;
		end
		csum = crank * TWIST_SCALE + tsum;
		for (int h = 0; h < 2; h++) begin
			erank = 0;
			for (int p = 0; p < HALF; p++)
				ep[p] = es[4*(HALF*h + p) +: 4];
			for (int p = 0; p < HALF; p++) begin
				term = ep[p];
				for (int q = 0; q < p; q++)
					if (ep[p] > ep[q])
						term -= 1;
				erank += term * EDGE_WEIGHT[p];
			end
			for (int p = 0; p < HALF; p++)
				fl[HALF-1-p] = ef[HALF*h + p];
			eidx[h] = {erank[ERANK_W-1:0], fl};
		end
		r.corner_index = csum[CIDX_W-1:0];
		r.first_edge_index = eidx[0];
		r.second_edge_index = eidx[1];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_index.delete();
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (ix.valid && ix.ready) begin
				if (expected_index.size() == 0) begin
					if (fail_count < MAX_REPORTS)
						$display("unexpected index transfer: corner %0d first %0d second %0d",
							ix.corner_index, ix.first_edge_index, ix.second_edge_index);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_index.pop_front();
					if (ix.corner_index !== want.corner_index ||
							ix.first_edge_index !== want.first_edge_index ||
							ix.second_edge_index !== want.second_edge_index) begin
						if (fail_count < MAX_REPORTS)
							$display("index mismatch: corner %0d/%0d first %0d/%0d second %0d/%0d (exp/act)",
								want.corner_index, ix.corner_index,
								want.first_edge_index, ix.first_edge_index,
								want.second_edge_index, ix.second_edge_index);
						fail_count <= fail_count + 1;
					end
				end
			end
			if (st.valid && st.ready)
				expected_index.insert(expected_index.size(),
					rank_cube_state(st.corner_slots, st.corner_twists,
					st.edge_slots, st.edge_flips));
			pending <= expected_index.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the cube_state_pattern_index bench: clock, reset, state stimulus with
// bursts and gaps, a stalling index receiver and the verdict.
// Depends on csi_pkg, csi_ifs, the block and csi_index_checker.
module testbench;
	import csi_pkg::*;

	typedef enum int {PERM_IDENTITY, PERM_REVERSED, PERM_SHUFFLED} perm_mode_t;
	typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_LONG_HOLD} rx_mode_t;

	localparam int RANDOM_STATES = 550;
	localparam int LONG_HOLD_CYCLES = 48;

	logic clk = 1'b0;
	logic arst_n;
	int   fail_count;
	int   pending;
	bit   random_phase;
	bit   long_hold_done;

	csi_state_if state_ch ();
	csi_index_if index_ch ();

	cube_state_pattern_index u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.state  (state_ch),
		.index  (index_ch)
	);

	csi_index_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.st         (state_ch),
		.ix         (index_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #1 clk = ~clk;

	function automatic logic [ESLOTS_W-1:0] piece_perm(perm_mode_t mode, int n, int w);
		int unsigned         p [EDGES];
		int unsigned         t;
		int                  r;
		logic [ESLOTS_W-1:0] v;
		v = '0;
		for (int k = 0; k < n; k++)
			p[k] = (mode == PERM_REVERSED) ? n - 1 - k : k;
		if (mode == PERM_SHUFFLED)
			for (int k = n - 1; k > 0; k--) begin
				r = $urandom_range(0, k);
				t = p[k];
				p[k] = p[r];
				p[r] = t;
			end
		for (int k = 0; k < n; k++)
			for (int b = 0; b < w; b++)
				v[w*k + b] = p[k][b];
		return v;
	endfunction

	function automatic logic [CTWIST_W-1:0] legal_twists();
		logic [CTWIST_W-1:0] v;
		for (int k = 0; k < TWISTS; k++)
			v[2*k +: 2] = 2'($urandom_range(0, 2));
		return v;
	endfunction

	task automatic send_state(logic [CSLOTS_W-1:0] cs, logic [CTWIST_W-1:0] ct,
			logic [ESLOTS_W-1:0] es, logic [EFLIPS_W-1:0] ef);
		state_ch.valid <= 1'b1;
		state_ch.corner_slots <= cs;
		state_ch.corner_twists <= ct;
		state_ch.edge_slots <= es;
		state_ch.edge_flips <= ef;
		@(posedge clk);
		while (!state_ch.ready)
			@(posedge clk);
	endtask

	task automatic wait_drained();
		state_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	initial begin
		int gap;
		int burst;
		arst_n <= 1'b0;
		state_ch.valid <= 1'b0;
		state_ch.corner_slots <= '0;
		state_ch.corner_twists <= '0;
		state_ch.edge_slots <= '0;
		state_ch.edge_flips <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_state(piece_perm(PERM_IDENTITY, CORNERS, 3), '0,
			piece_perm(PERM_IDENTITY, EDGES, 4), '0);
		send_state(piece_perm(PERM_REVERSED, CORNERS, 3), 14'h2AAA,
			piece_perm(PERM_REVERSED, EDGES, 4), 12'hFFF);
		send_state('0, '0, '0, '0);
		send_state('1, '1, '1, '1);
		send_state(piece_perm(PERM_IDENTITY, CORNERS, 3), '1,
			piece_perm(PERM_IDENTITY, EDGES, 4), 12'h801);
		send_state(piece_perm(PERM_REVERSED, CORNERS, 3), 14'h1555,
			48'hFFFF_FFFF_FFFF, 12'h000);
		send_state(24'h249249, 14'h3333, 48'h5555_5555_5555, 12'hA5C);
		send_state(24'hDB6DB6, 14'h0CCC, 48'hFEDC_BA98_7654, 12'h5A3);
		send_state(piece_perm(PERM_SHUFFLED, CORNERS, 3), 14'h2AAA,
			48'hCDEF_0123_BA98, 12'h03F);
		send_state(piece_perm(PERM_IDENTITY, CORNERS, 3), 14'h0001,
			piece_perm(PERM_REVERSED, EDGES, 4), 12'hFC0);
		repeat (10)
			send_state(piece_perm(PERM_SHUFFLED, CORNERS, 3), legal_twists(),
				piece_perm(PERM_SHUFFLED, EDGES, 4), 12'($urandom));
		wait_drained();

		random_phase = 1'b1;
		burst = 0;
		for (int n = 0; n < RANDOM_STATES; n++) begin
			if (n == RANDOM_STATES / 2)
				wait_drained();
			if (burst == 0) begin
				burst = $urandom_range(1, 24);
				gap = $urandom_range(0, 6);
				if (gap != 0) begin
					state_ch.valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			burst--;
			if ($urandom_range(0, 4) != 0)
				send_state(piece_perm(PERM_SHUFFLED, CORNERS, 3), legal_twists(),
					piece_perm(PERM_SHUFFLED, EDGES, 4), 12'($urandom));
			else
				send_state(24'($urandom), 14'($urandom), {16'($urandom), 32'($urandom)},
					12'($urandom));
		end
		wait_drained();
		repeat (8) @(posedge clk);

		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		rx_mode_t mode;
		int len;
		int period;
		index_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			len = $urandom_range(8, 40);
			if (random_phase && !long_hold_done)
				mode = RX_LONG_HOLD;
			else if ($urandom_range(0, 15) == 0)
				mode = RX_LONG_HOLD;
			else
				mode = rx_mode_t'($urandom_range(0, 2));
			case (mode)
			RX_OPEN: begin
				index_ch.ready <= 1'b1;
				repeat (len) @(posedge clk);
			end
			RX_RANDOM: begin
				repeat (len) begin
					index_ch.ready <= 1'($urandom_range(0, 1));
					@(posedge clk);
				end
			end
			RX_PERIODIC: begin
				period = $urandom_range(2, 5);
				for (int c = 0; c < len; c++) begin
					index_ch.ready <= (c % period) != 0;
					@(posedge clk);
				end
			end
			default: begin
				long_hold_done = 1'b1;
				index_ch.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end
			endcase
		end
	end

	initial begin
		#400000;
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/csi_pkg.sv
sv/csi_ifs.sv
sv/csi_compare.sv
sv/csi_weigh.sv
sv/csi_scale.sv
sv/cube_state_pattern_index.sv
bench/csi_index_checker.sv
bench/testbench.sv
